// ----- hw/rtl/scht_pkg.sv -----
// Shared types, constants and helpers for the squared-cost segmentation block.
// Used by scht_ctrl, scht_dp and squared_cost_segmentation_cht.
`default_nettype none

package scht_pkg;

  localparam int MAX_ITEMS   = 1024;
  localparam int LENGTH_BITS = 16;
  localparam int TGT_W       = 26;
  localparam int PFX_W       = 27;
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = 10;
  localparam int COST_W      = 56;
  localparam int MA_W        = 28;
  localparam int MB_W        = 27;
  localparam int PROD_W      = 55;
  localparam int WIDE_W      = 83;
  localparam int HALF_W      = 28;
  localparam int ENT_W       = PFX_W + COST_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  typedef struct packed {
    logic                   first_item;
    logic [LENGTH_BITS-1:0] item_length;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] best_cost;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [PFX_W-1:0]  x;
    logic [COST_W-1:0] y;
  } hull_ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FCHK, S_FRA, S_FRB, S_FMUL, S_FCMP,
    S_JRD, S_JLAT, S_CM1, S_CM2, S_CM3, S_CY,
    S_BCHK, S_BRA, S_BRB, S_BDIF, S_BM1, S_BM2, S_BM3, S_BM4, S_BM5, S_BCMP,
    S_PUSH, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_FRD, OP_FRA, OP_FRB, OP_FMUL, OP_FPOP,
    OP_JRD, OP_JLAT, OP_CM1, OP_CM2, OP_CM3, OP_CY,
    OP_BRD, OP_BRA, OP_BRB, OP_BDIF, OP_BM1, OP_BM2, OP_BM3, OP_BM4, OP_BM5,
    OP_BPOP, OP_PUSH, OP_OUT
  } op_t;

  typedef struct packed {
    logic ovf;
    logic fr_cond;
    logic fr_pop;
    logic yn_ok;
    logic bk_cond;
    logic bk_pop;
    logic out_free;
  } status_t;

  // a < b for sign-magnitude values; negative zero counts as zero
  function automatic logic lt_sm(input logic na, input logic [WIDE_W-1:0] ma,
                                 input logic nb, input logic [WIDE_W-1:0] mb);
    logic sa;
    logic sb;
    logic r;
    sa = na && (ma != '0);
    sb = nb && (mb != '0);
    if (sa != sb) begin
      r = sa;
    end else if (!sa) begin
      r = (ma < mb);
    end else begin
      r = (ma > mb);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scht_ctrl.sv -----
// Sequencer for the hull update: front pops, cost, back pops, push, result.
// Depends on scht_pkg; drives scht_dp through op codes.
`default_nettype none

module scht_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire scht_pkg::status_t st,
  output scht_pkg::op_t         op
);

  scht_pkg::state_t state_r;
  scht_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scht_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = scht_pkg::OP_NONE;
    in_stall  = 1'b1;
    unique case (state_r)
      scht_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op        = scht_pkg::OP_START;
          state_nxt = scht_pkg::S_FCHK;
        end
      end
      scht_pkg::S_FCHK: begin
        op = scht_pkg::OP_FRD;
        if (st.ovf) begin
          state_nxt = scht_pkg::S_FIN;
        end else if (st.fr_cond) begin
          state_nxt = scht_pkg::S_FRA;
        end else begin
          state_nxt = scht_pkg::S_JRD;
        end
      end
      scht_pkg::S_FRA: begin
        op        = scht_pkg::OP_FRA;
        state_nxt = scht_pkg::S_FRB;
      end
      scht_pkg::S_FRB: begin
        op        = scht_pkg::OP_FRB;
        state_nxt = scht_pkg::S_FMUL;
      end
      scht_pkg::S_FMUL: begin
        op        = scht_pkg::OP_FMUL;
        state_nxt = scht_pkg::S_FCMP;
      end
      scht_pkg::S_FCMP: begin
        if (st.fr_pop) begin
          op        = scht_pkg::OP_FPOP;
          state_nxt = scht_pkg::S_FCHK;
        end else begin
          state_nxt = scht_pkg::S_JRD;
        end
      end
      scht_pkg::S_JRD: begin
        op        = scht_pkg::OP_JRD;
        state_nxt = scht_pkg::S_JLAT;
      end
      scht_pkg::S_JLAT: begin
        op        = scht_pkg::OP_JLAT;
        state_nxt = scht_pkg::S_CM1;
      end
      scht_pkg::S_CM1: begin
        op        = scht_pkg::OP_CM1;
        state_nxt = scht_pkg::S_CM2;
      end
      scht_pkg::S_CM2: begin
        op        = scht_pkg::OP_CM2;
        state_nxt = scht_pkg::S_CM3;
      end
      scht_pkg::S_CM3: begin
        op        = scht_pkg::OP_CM3;
        state_nxt = st.yn_ok ? scht_pkg::S_CY : scht_pkg::S_FIN;
      end
      scht_pkg::S_CY: begin
        op        = scht_pkg::OP_CY;
        state_nxt = scht_pkg::S_BCHK;
      end
      scht_pkg::S_BCHK: begin
        op        = scht_pkg::OP_BRD;
        state_nxt = st.bk_cond ? scht_pkg::S_BRA : scht_pkg::S_PUSH;
      end
      scht_pkg::S_BRA: begin
        op        = scht_pkg::OP_BRA;
        state_nxt = scht_pkg::S_BRB;
      end
      scht_pkg::S_BRB: begin
        op        = scht_pkg::OP_BRB;
        state_nxt = scht_pkg::S_BDIF;
      end
      scht_pkg::S_BDIF: begin
        op        = scht_pkg::OP_BDIF;
        state_nxt = scht_pkg::S_BM1;
      end
      scht_pkg::S_BM1: begin
        op        = scht_pkg::OP_BM1;
        state_nxt = scht_pkg::S_BM2;
      end
      scht_pkg::S_BM2: begin
        op        = scht_pkg::OP_BM2;
        state_nxt = scht_pkg::S_BM3;
      end
      scht_pkg::S_BM3: begin
        op        = scht_pkg::OP_BM3;
        state_nxt = scht_pkg::S_BM4;
      end
      scht_pkg::S_BM4: begin
        op        = scht_pkg::OP_BM4;
        state_nxt = scht_pkg::S_BM5;
      end
      scht_pkg::S_BM5: begin
        op        = scht_pkg::OP_BM5;
        state_nxt = scht_pkg::S_BCMP;
      end
      scht_pkg::S_BCMP: begin
        if (st.bk_pop) begin
          op        = scht_pkg::OP_BPOP;
          state_nxt = scht_pkg::S_BCHK;
        end else begin
          state_nxt = scht_pkg::S_PUSH;
        end
      end
      scht_pkg::S_PUSH: begin
        op        = scht_pkg::OP_PUSH;
        state_nxt = scht_pkg::S_FIN;
      end
      scht_pkg::S_FIN: begin
        if (st.out_free) begin
          op        = scht_pkg::OP_OUT;
          state_nxt = scht_pkg::S_IDLE;
        end
      end
      default: state_nxt = scht_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scht_dp.sv -----
// Datapath: prefix/count/deque pointers, hull RAM, shared 28x27 multiplier,
// sign-magnitude compares and the result register. Depends on scht_pkg, scht_ram.
`default_nettype none

module scht_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire scht_pkg::op_t               op,
  input  wire scht_pkg::in_item_t          in_data,
  input  wire logic [scht_pkg::TGT_W-1:0]  tgt,
  input  wire logic                        out_stall,
  output scht_pkg::status_t                st,
  output logic                             out_valid,
  output scht_pkg::out_item_t              out_data
);

  logic [scht_pkg::PFX_W-1:0]  prefix_r;
  logic [scht_pkg::CNT_W-1:0]  count_r;
  logic [scht_pkg::CNT_W-1:0]  head_r;
  logic [scht_pkg::CNT_W-1:0]  tail_r;
  logic                        ovf_r;
  logic                        out_valid_r;
  scht_pkg::out_item_t         out_data_r;

  scht_pkg::hull_ent_t         pa_r;
  scht_pkg::hull_ent_t         pb_r;
  logic                        rd_zero_r;
  logic [scht_pkg::PROD_W-1:0] prod_r;
  logic [scht_pkg::COST_W-1:0] cost_r;
  logic [scht_pkg::COST_W-1:0] ynew_r;
  logic [scht_pkg::PFX_W-1:0]  dx1_r;
  logic [scht_pkg::PFX_W-1:0]  dx2_r;
  logic [scht_pkg::COST_W-1:0] dy1_r;
  logic [scht_pkg::COST_W-1:0] dy2_r;
  logic                        n1_r;
  logic                        n2_r;
  logic [scht_pkg::WIDE_W-1:0] p1_r;
  logic [scht_pkg::WIDE_W-1:0] p2_r;

  logic [scht_pkg::PFX_W-1:0]  tgt1;
  logic [scht_pkg::PFX_W-1:0]  w_mag;
  logic                        w_neg;
  logic [scht_pkg::PFX_W-1:0]  dxa;
  logic [scht_pkg::PFX_W-1:0]  d_sx;
  logic [scht_pkg::PFX_W-1:0]  m_mag;
  logic [scht_pkg::CNT_W-1:0]  head_p1;
  logic [scht_pkg::CNT_W-1:0]  tail_m1;
  logic [scht_pkg::CNT_W-1:0]  tail_p1;
  logic [scht_pkg::MA_W-1:0]   mul_a;
  logic [scht_pkg::MB_W-1:0]   mul_b;
  logic [scht_pkg::PROD_W-1:0] mul_p;
  logic [scht_pkg::ADDR_W-1:0] raddr;
  logic                        we;
  logic [scht_pkg::ENT_W-1:0]  ram_q;
  scht_pkg::hull_ent_t         rdat;
  scht_pkg::hull_ent_t         went;
  logic                        first;
  logic [scht_pkg::CNT_W-1:0]  cnt_eff;
  logic [scht_pkg::PFX_W-1:0]  pfx_eff;

  assign tgt1    = {1'b0, tgt} + scht_pkg::PFX_W'(1);
  assign w_neg   = prefix_r < tgt1;
  assign w_mag   = w_neg ? (tgt1 - prefix_r) : (prefix_r - tgt1);
  assign dxa     = pb_r.x - pa_r.x;
  assign d_sx    = prefix_r - pa_r.x;
  assign m_mag   = (d_sx < tgt1) ? (tgt1 - d_sx) : (d_sx - tgt1);
  assign head_p1 = head_r + scht_pkg::CNT_W'(1);
  assign tail_m1 = tail_r - scht_pkg::CNT_W'(1);
  assign tail_p1 = tail_r + scht_pkg::CNT_W'(1);
  assign we      = (op == scht_pkg::OP_PUSH) && (tail_p1 < scht_pkg::MAX_CNT);
  assign went    = '{x: prefix_r, y: ynew_r};
  // entry zero is never written; it always holds the origin point
  assign rdat    = rd_zero_r ? '0 : scht_pkg::hull_ent_t'(ram_q);

  assign first   = in_data.first_item;
  assign cnt_eff = first ? '0 : count_r;
  assign pfx_eff = first ? '0 : prefix_r;

  always_comb begin
    raddr = '0;
    case (op)
      scht_pkg::OP_FRD: raddr = head_r[scht_pkg::ADDR_W-1:0];
      scht_pkg::OP_FRA: raddr = head_p1[scht_pkg::ADDR_W-1:0];
      scht_pkg::OP_JRD: begin
        raddr = (head_r < scht_pkg::MAX_CNT) ? head_r[scht_pkg::ADDR_W-1:0] : '0;
      end
      scht_pkg::OP_BRD: raddr = tail_m1[scht_pkg::ADDR_W-1:0];
      scht_pkg::OP_BRA: raddr = tail_r[scht_pkg::ADDR_W-1:0];
      default:          raddr = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      scht_pkg::OP_FMUL: begin
        mul_a = {w_mag, 1'b0};
        mul_b = dxa;
      end
      scht_pkg::OP_CM1: begin
        mul_a = {1'b0, pa_r.x};
        mul_b = pa_r.x;
      end
      scht_pkg::OP_CM2: begin
        mul_a = {1'b0, m_mag};
        mul_b = m_mag;
      end
      scht_pkg::OP_CM3: begin
        mul_a = {1'b0, prefix_r};
        mul_b = prefix_r;
      end
      scht_pkg::OP_BM1: begin
        mul_a = dy1_r[scht_pkg::HALF_W-1:0];
        mul_b = dx2_r;
      end
      scht_pkg::OP_BM2: begin
        mul_a = dy1_r[scht_pkg::COST_W-1:scht_pkg::HALF_W];
        mul_b = dx2_r;
      end
      scht_pkg::OP_BM3: begin
        mul_a = dy2_r[scht_pkg::HALF_W-1:0];
        mul_b = dx1_r;
      end
      scht_pkg::OP_BM4: begin
        mul_a = dy2_r[scht_pkg::COST_W-1:scht_pkg::HALF_W];
        mul_b = dx1_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  scht_ram #(.WIDTH(scht_pkg::ENT_W), .DEPTH(scht_pkg::MAX_ITEMS)) u_hull (
    .clk   (clk),
    .we    (we),
    .waddr (tail_p1[scht_pkg::ADDR_W-1:0]),
    .wdata (went),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == scht_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        scht_pkg::OP_START: begin
          if (first) begin
            head_r <= '0;
            tail_r <= '0;
          end
          ovf_r <= (cnt_eff >= scht_pkg::MAX_CNT);
          if (cnt_eff < scht_pkg::MAX_CNT) begin
            prefix_r <= pfx_eff + scht_pkg::PFX_W'(in_data.item_length)
                        + scht_pkg::PFX_W'(1);
            count_r  <= cnt_eff + scht_pkg::CNT_W'(1);
          end
        end
        scht_pkg::OP_FPOP: head_r <= head_p1;
        scht_pkg::OP_BPOP: begin
          if (head_r == tail_r) begin
            head_r <= head_r - scht_pkg::CNT_W'(1);
          end
          tail_r <= tail_m1;
        end
        scht_pkg::OP_PUSH: begin
          if (tail_p1 < scht_pkg::MAX_CNT) begin
            tail_r <= tail_p1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_zero_r <= (raddr == '0);
    prod_r    <= mul_p;
    case (op)
      scht_pkg::OP_FRA:  pa_r <= rdat;
      scht_pkg::OP_FRB:  pb_r <= rdat;
      scht_pkg::OP_JLAT: pa_r <= rdat;
      scht_pkg::OP_BRA:  pa_r <= rdat;
      scht_pkg::OP_BRB:  pb_r <= rdat;
      scht_pkg::OP_FMUL: begin
        n1_r  <= pb_r.y < pa_r.y;
        dy1_r <= (pb_r.y < pa_r.y) ? (pa_r.y - pb_r.y) : (pb_r.y - pa_r.y);
        n2_r  <= w_neg;
      end
      scht_pkg::OP_CM2: cost_r <= pa_r.y - scht_pkg::COST_W'(prod_r);
      scht_pkg::OP_CM3: cost_r <= cost_r + scht_pkg::COST_W'(prod_r);
      scht_pkg::OP_CY:  ynew_r <= cost_r + scht_pkg::COST_W'(prod_r);
      scht_pkg::OP_BDIF: begin
        dx1_r <= dxa;
        dx2_r <= prefix_r - pb_r.x;
        n1_r  <= pb_r.y < pa_r.y;
        dy1_r <= (pb_r.y < pa_r.y) ? (pa_r.y - pb_r.y) : (pb_r.y - pa_r.y);
        n2_r  <= ynew_r < pb_r.y;
        dy2_r <= (ynew_r < pb_r.y) ? (pb_r.y - ynew_r) : (ynew_r - pb_r.y);
      end
      scht_pkg::OP_BM2: p1_r <= scht_pkg::WIDE_W'(prod_r);
      scht_pkg::OP_BM3: p1_r <= p1_r + {prod_r, {scht_pkg::HALF_W{1'b0}}};
      scht_pkg::OP_BM4: p2_r <= scht_pkg::WIDE_W'(prod_r);
      scht_pkg::OP_BM5: p2_r <= p2_r + {prod_r, {scht_pkg::HALF_W{1'b0}}};
      scht_pkg::OP_OUT: begin
        out_data_r.best_cost <= ovf_r ? '0 : cost_r;
        out_data_r.overflow  <= ovf_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.ovf      = ovf_r;
    st.fr_cond  = (head_r < tail_r) && (tail_r < scht_pkg::MAX_CNT);
    st.fr_pop   = scht_pkg::lt_sm(n1_r, scht_pkg::WIDE_W'(dy1_r),
                                  n2_r, scht_pkg::WIDE_W'(prod_r));
    st.yn_ok    = count_r < scht_pkg::MAX_CNT;
    st.bk_cond  = (tail_r != '0) && (tail_r < scht_pkg::MAX_CNT);
    // pop while slope(tail-1,tail) > slope(tail,new)
    st.bk_pop   = scht_pkg::lt_sm(n2_r, p2_r, n1_r, p1_r);
    st.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/squared_cost_segmentation_cht.sv -----
// Squared-cost segmentation block: APB target register, controller and datapath.
// Depends on scht_pkg, scht_ctrl, scht_dp (and scht_ram inside scht_dp).
//
//   Input channel (in_valid/in_stall/in_data): one request per item, carrying
//   first_item (restart the sequence) and item_length. Output channel
//   (out_valid/out_stall/out_data): one result per request, best_cost and
//   overflow, in request order. The APB register at address 0 holds
//   segment_target; write it only while the block is idle.
//   A request is taken, then front tests (hull reads, a multiply, a compare)
//   drop points from the head while they hold, the cost is worked out, back
//   tests (hull reads, differences, multiply steps, a compare) drop points
//   from the tail, the new point is pushed and the result is registered. An
//   ignored request (overflow) goes straight to its result. The 28x27
//   multiplier is shared and the hull RAM reads one entry per cycle.
//   One request is worked on at a time; in_stall is high while it runs. The
//   result waits in an output register and the next request is taken while
//   it waits; a stalled receiver holds the block only at its next result.
//   Reset (rst_n low, synchronous) empties the output, clears the prefix,
//   count and hull pointers and sets segment_target to zero.
`default_nettype none

module squared_cost_segmentation_cht (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire scht_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output scht_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  logic [scht_pkg::TGT_W-1:0] tgt_r;
  scht_pkg::status_t          st;
  scht_pkg::op_t              op;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      tgt_r <= pwdata[scht_pkg::TGT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32 - scht_pkg::TGT_W){1'b0}}, tgt_r} : '0;

  scht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  scht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .tgt       (tgt_r),
    .out_stall (out_stall),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
